### src/idd_pkg.sv
// ----------------------------------------------------------------------------
// idd_pkg: shared constants and helpers for the int8 dot dequant unit
// Accumulator width and range, default lane count and max K, canonical NaN.
// ----------------------------------------------------------------------------
package idd_pkg;

  localparam int unsigned AccW        = 28;
  localparam int unsigned DefLanes    = 4;
  localparam int unsigned DefMaxK     = 4096;
  localparam logic [31:0] CanonNan    = 32'h7FC0_0000;
  localparam logic signed [AccW-1:0] AccMax = 28'sh7FF_FFFF;
  localparam logic signed [AccW-1:0] AccMin = -28'sh800_0000;

  // saturate a wide signed value to the accumulator range
  function automatic logic signed [AccW-1:0] sat28(input logic signed [35:0] v);
    logic signed [AccW-1:0] r;
    if (v > 36'(AccMax)) r = AccMax;
    else if (v < 36'(AccMin)) r = AccMin;
    else r = v[AccW-1:0];
    return r;
  endfunction

endpackage

### src/idd_lane.sv
// ----------------------------------------------------------------------------
// idd_lane: one int8 multiply lane
// Multiplies one weight byte by one activation byte when the lane is enabled.
// ----------------------------------------------------------------------------
module idd_lane (
  input  logic signed [7:0]  w_i,
  input  logic signed [7:0]  a_i,
  input  logic               en_i,
  output logic signed [15:0] prod_o
);

  // gated signed product
  assign prod_o = en_i ? (w_i * a_i) : 16'sd0;

endmodule

### src/idd_fmul.sv
// ----------------------------------------------------------------------------
// idd_fmul: single precision multiplier, round to nearest even
// Combinational: the product is held in an output register by the caller.
// ----------------------------------------------------------------------------
module idd_fmul (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  logic        sa, sb, sy;
  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] ma, mb;
  logic signed [10:0] xa, xb, ex;
  logic [47:0] prod;
  logic [47:0] pn;
  logic [5:0]  lz;
  logic [24:0] mant;
  logic        grd, stk;
  logic signed [10:0] sh;
  logic [49:0] pw;
  logic [24:0] rm;
  logic [8:0]  eout;

  always_comb begin
    sa = a_i[31]; sb = b_i[31]; sy = sa ^ sb;
    ea = a_i[30:23]; eb = b_i[30:23];
    fa = a_i[22:0]; fb = b_i[22:0];
    a_nan = (ea == 8'hFF) && (fa != 0);
    b_nan = (eb == 8'hFF) && (fb != 0);
    a_inf = (ea == 8'hFF) && (fa == 0);
    b_inf = (eb == 8'hFF) && (fb == 0);
    a_zero = (ea == 0) && (fa == 0);
    b_zero = (eb == 0) && (fb == 0);
    ma = {(ea != 0), fa};
    mb = {(eb != 0), fb};
    xa = (ea == 0) ? 11'sd1 : 11'($signed({3'b0, ea}));
    xb = (eb == 0) ? 11'sd1 : 11'($signed({3'b0, eb}));
    prod = ma * mb;
    // normalize: leading one to bit 47
    lz = '0;
    for (int i = 0; i < 48; i++) if (prod[i]) lz = 6'(47 - i);
    pn = prod << lz;
    // exponent of bit 47: xa + xb - 127 + 1 - lz
    ex = xa + xb - 11'sd126 - 11'($signed({5'b0, lz}));
    sh = '0;
    pw = '0;
    mant = '0;
    grd = 1'b0;
    stk = 1'b0;
    rm = '0;
    eout = '0;
    y_o = '0;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      y_o = idd_pkg::CanonNan;
    end else if (a_inf || b_inf) begin
      y_o = {sy, 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      y_o = {sy, 31'd0};
    end else begin
      // subnormal: shift right further
      sh = (ex < 11'sd1) ? (11'sd1 - ex) : 11'sd0;
      if (sh > 11'sd26) sh = 11'sd26;
      pw = {pn, 2'b00} >> sh;
      mant = {1'b0, pw[49:26]};
      grd = pw[25];
      stk = |pw[24:0] | (|(({pn, 2'b00}) & ((50'd1 << sh) - 50'd1)));
      rm = mant + 25'(grd && (stk || mant[0]));
      if (ex < 11'sd1) begin
        // subnormal or rounds up to min normal
        y_o = {sy, 31'(rm)};
      end else begin
        eout = 9'(ex);
        if (rm[24]) begin
          eout = eout + 9'd1;
          rm = rm >> 1;
        end
        if (eout >= 9'd255) y_o = {sy, 8'hFF, 23'd0};
        else y_o = {sy, eout[7:0], rm[22:0]};
      end
    end
  end

endmodule

### src/int8_dot_dequant_unit.sv
// Results: a last request passes the correction register, the convert stage
// and the two float multiply stages before its result is shown.
// Throughput: one request per cycle while no result is pending; a last
// request stalls input while in the pipeline and until its result is taken.
// Reset: accumulator cleared, asymmetric mode off, no result pending.
// ----------------------------------------------------------------------------
// int8_dot_dequant_unit: int8 dot product with dequantization
// Parallel int8 lanes, adder tree merge, correction and float scaling.
// ----------------------------------------------------------------------------
module int8_dot_dequant_unit #(
  parameter int unsigned LANES = idd_pkg::DefLanes
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [8*LANES-1:0]      weight_bytes_i,
  input  logic [8*LANES-1:0]      activation_bytes_i,
  input  logic [2:0]              lane_count_i,
  input  logic                    last_of_dot_i,
  input  logic [31:0]             weight_scale_i,
  input  logic [31:0]             activation_scale_i,
  input  logic signed [19:0]      weight_row_sum_i,
  input  logic signed [7:0]       zero_point_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [31:0]             scaled_result_o,
  output logic signed [27:0]      corrected_dot_o
);

  localparam int unsigned EffLanes = (LANES < 4) ? LANES : 4;
  localparam int unsigned SumW = 16 + $clog2(LANES + 1) + 1;

  logic asym_q;
  logic signed [27:0] acc_q, acc_d;
  logic signed [15:0] prod [LANES];
  logic signed [SumW-1:0] lane_sum;
  logic in_acc;
  // pipeline valid bits: s1 corrected int, s2 conversion, s3 first mul
  logic v1_q, v2_q, v3_q;
  logic signed [27:0] dot1_q;
  logic [31:0] ws1_q, as1_q, as2_q, as3_q, ws2_q;
  logic [31:0] f2_q, m3_q, r_q;
  logic signed [27:0] dot2_q, dot3_q, dot4_q;
  logic [31:0] f_cvt, m_mul, r_mul;
  logic busy;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) asym_q <= 1'b0;
    else if (cfg_valid_i) asym_q <= cfg_data_i;
  end

  // lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    idd_lane u_lane (
      .w_i   (weight_bytes_i[8*g +: 8]),
      .a_i   (activation_bytes_i[8*g +: 8]),
      .en_i  ((g < EffLanes) && (32'(lane_count_i) > g)),
      .prod_o(prod[g])
    );
  end

  // merge lanes
  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < LANES; i++) lane_sum = lane_sum + SumW'(prod[i]);
  end

  assign busy = v1_q | v2_q | v3_q | out_valid_o;
  assign in_stall_o = busy;
  assign in_acc = in_valid_i & ~in_stall_o;

  // accumulate with saturation
  always_comb begin
    acc_d = idd_pkg::sat28(36'(acc_q) + 36'(lane_sum));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; out_valid_o <= 1'b0;
    end else begin
      v1_q <= in_acc & last_of_dot_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (v3_q) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      if (in_acc) acc_q <= last_of_dot_i ? '0 : acc_d;
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    if (in_acc && last_of_dot_i) begin
      dot1_q <= asym_q ? idd_pkg::sat28(36'(acc_d)
                                        - 36'(zero_point_i) * 36'(weight_row_sum_i))
                       : acc_d;
      ws1_q <= weight_scale_i;
      as1_q <= activation_scale_i;
    end
    if (v1_q) begin f2_q <= f_cvt; dot2_q <= dot1_q; ws2_q <= ws1_q; as2_q <= as1_q; end
    if (v2_q) begin m3_q <= m_mul; dot3_q <= dot2_q; as3_q <= as2_q; end
    if (v3_q) begin r_q <= r_mul; dot4_q <= dot3_q; end
  end

  // int to float conversion, round to nearest even
  logic [27:0] mag;
  logic [4:0]  p;
  logic [27:0] mn;
  logic [24:0] mr;
  logic        gb, sb;
  logic [31:0] body;
  always_comb begin
    mag = dot1_q[27] ? 28'(-dot1_q) : 28'(dot1_q);
    p = '0;
    for (int i = 0; i < 28; i++) if (mag[i]) p = 5'(i);
    mn = mag << (5'd27 - p);
    gb = mn[3];
    sb = |mn[2:0];
    // 24 bit significand, a carry out bumps the exponent
    mr = {1'b0, mn[27:4]} + 25'(gb && (sb || mn[4]));
    // implicit bit: exponent field p+126 plus leading bit at 23 gives p+127
    body = ((32'(p) + 32'd126) << 23) + 32'(mr);
    if (mag == 0) f_cvt = '0;
    else f_cvt = {dot1_q[27], body[30:0]};
  end

  idd_fmul u_mul1 (.a_i(f2_q), .b_i(ws2_q), .y_o(m_mul));
  idd_fmul u_mul2 (.a_i(m3_q), .b_i(as3_q), .y_o(r_mul));

  assign scaled_result_o = r_q;
  assign corrected_dot_o = dot4_q;

`ifndef SYNTHESIS
  a_one_hot_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({v1_q, v2_q, v3_q}) <= 1) else $error("pipe overlap");
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> in_stall_o) else $error("accepted while busy");
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> acc_q == '0) else $error("acc not cleared");
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |=> out_valid_o) else $error("result lost");
`endif

endmodule

### test/int8_dot_dequant_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_dot_dequant_unit_tb: self-checking bench for the int8 dot dequant unit
// Streams directed and random dot products, predicts the integer sum and
// the scaled float result per request, and checks each result in order.
// ----------------------------------------------------------------------------
module int8_dot_dequant_unit_tb;

  typedef struct packed {
    logic [31:0]        wbytes;
    logic [31:0]        abytes;
    logic [2:0]         lanes;
    logic               last;
    logic [31:0]        wscale;
    logic [31:0]        ascale;
    logic signed [19:0] row_sum;
    logic signed [7:0]  zp;
  } dot_req_t;

  typedef struct packed {
    logic [31:0]                    scaled;
    logic signed [idd_pkg::AccW-1:0] dot;
  } dot_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  dot_req_t req_q = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] scaled_result_o;
  logic signed [27:0] corrected_dot_o;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  logic mode_q = 1'b0;
  logic signed [idd_pkg::AccW-1:0] acc_q = '0;
  dot_res_t results_due[$];

  always #5 clk_i = ~clk_i;

  int8_dot_dequant_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .weight_bytes_i     (req_q.wbytes),
    .activation_bytes_i (req_q.abytes),
    .lane_count_i       (req_q.lanes),
    .last_of_dot_i      (req_q.last),
    .weight_scale_i     (req_q.wscale),
    .activation_scale_i (req_q.ascale),
    .weight_row_sum_i   (req_q.row_sum),
    .zero_point_i       (req_q.zp),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .scaled_result_o    (scaled_result_o),
    .corrected_dot_o    (corrected_dot_o)
  );

  // single bits to an exact double
  function automatic real single_to_real(logic [31:0] s);
    logic [63:0] d;
    logic [23:0] f;
    int ex;
    f = {1'b0, s[22:0]};
    ex = -126;
    if (s[30:23] == 8'hFF) begin
      d = {s[31], 11'h7FF, (s[22:0] != 0) ? 52'h8_0000_0000_0000 : 52'h0};
    end else if (s[30:23] == 8'h00) begin
      if (f == 0) begin
        d = {s[31], 63'b0};
      end else begin
        while (!f[23]) begin
          f = f << 1;
          ex--;
        end
        d = {s[31], 11'(ex + 1023), f[22:0], 29'b0};
      end
    end else begin
      d = {s[31], 11'(int'(s[30:23]) - 127 + 1023), s[22:0], 29'b0};
    end
    return $bitstoreal(d);
  endfunction

  // double to single bits, round to nearest even, subnormals kept
  function automatic logic [31:0] real_to_single(real r);
    logic [63:0] d, m, q, rem, half;
    int ex, sh;
    logic [31:0] sgn;
    d = $realtobits(r);
    sgn = {d[63], 31'b0};
    ex = int'(d[62:52]) - 1023;
    m = {11'b0, 1'b1, d[51:0]};
    if (d[62:52] == 11'h7FF)
      return sgn | ((d[51:0] != 0) ? idd_pkg::CanonNan : 32'h7F80_0000);
    if (d[62:52] == 11'h000) return sgn;
    if (ex > 127) return sgn | 32'h7F80_0000;
    sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (sh > 60) return sgn;
    q = m >> sh;
    rem = m & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    if (ex >= -126) return sgn | (32'((ex + 127) << 23) + q[31:0] - 32'h0080_0000);
    return sgn | q[31:0];
  endfunction

  // accumulate one request, produce the dequantized result on last
  function automatic bit dequant_step(dot_req_t r, output dot_res_t res);
    longint sum, dot;
    int n;
    logic [31:0] s1, s2;
    sum = 0;
    n = (r.lanes > 4) ? 4 : r.lanes;
    for (int i = 0; i < n; i++)
      sum += longint'($signed(r.wbytes[8*i +: 8])) * longint'($signed(r.abytes[8*i +: 8]));
    sum += acc_q;
    if (sum > idd_pkg::AccMax) sum = idd_pkg::AccMax;
    if (sum < idd_pkg::AccMin) sum = idd_pkg::AccMin;
    acc_q = idd_pkg::AccW'(sum);
    res = '0;
    if (!r.last) return 1'b0;
    dot = sum;
    if (mode_q) begin
      dot = dot - longint'($signed(r.zp)) * longint'($signed(r.row_sum));
      if (dot > idd_pkg::AccMax) dot = idd_pkg::AccMax;
      if (dot < idd_pkg::AccMin) dot = idd_pkg::AccMin;
    end
    s1 = real_to_single(real'(dot));
    s1 = real_to_single(single_to_real(s1) * single_to_real(r.wscale));
    s2 = real_to_single(single_to_real(s1) * single_to_real(r.ascale));
    if (s2[30:23] == 8'hFF && s2[22:0] != 0) s2 = idd_pkg::CanonNan;
    res.scaled = s2;
    res.dot = idd_pkg::AccW'(dot);
    acc_q = '0;
    return 1'b1;
  endfunction

  // sample handshakes mid-cycle, they are accepted at the next rising edge
  always @(negedge clk_i) begin
    dot_res_t res;
    dot_res_t due;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) mode_q <= cfg_data_i;
      if (in_valid_i && !in_stall_o) begin
        if (dequant_step(req_q, res)) results_due.push_back(res);
      end
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: scaled_result %h corrected_dot %0d",
                 scaled_result_o, corrected_dot_o);
          errors++;
        end else begin
          due = results_due.pop_front();
          if (scaled_result_o !== due.scaled) begin
            $error("scaled_result: expected %h, got %h", due.scaled, scaled_result_o);
            errors++;
          end
          if (corrected_dot_o !== due.dot) begin
            $error("corrected_dot: expected %0d, got %0d", due.dot, corrected_dot_o);
            errors++;
          end
        end
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_req(dot_req_t r);
    logic st;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_q <= r;
    in_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      st = in_stall_o;
      @(posedge clk_i);
    end while (st);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    logic rdy;
    drain();
    cfg_data_i <= m;
    cfg_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_scale();
    if ($urandom_range(3) == 0) return $urandom;
    return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
  endfunction

  function automatic dot_req_t rand_req(bit last);
    dot_req_t r;
    r.wbytes = $urandom;
    r.abytes = $urandom;
    r.lanes = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
    r.last = last;
    r.wscale = pick_scale();
    r.ascale = pick_scale();
    r.row_sum = 20'($urandom);
    r.zp = 8'($urandom);
    return r;
  endfunction

  function automatic dot_req_t mk(logic [31:0] w, logic [31:0] a, logic [2:0] n, logic l,
                                  logic [31:0] ws, logic [31:0] as,
                                  logic signed [19:0] rs, logic signed [7:0] z);
    dot_req_t r;
    r = '{w, a, n, l, ws, as, rs, z};
    return r;
  endfunction

  // lane extremes, odd lane counts and float special cases
  task automatic test_directed();
    write_mode(1'b1);
    send_req(mk(32'h8080_8080, 32'h8080_8080, 3'd4, 1'b1, 32'h3F80_0000,
                32'h3F80_0000, 20'sh80000, -8'sd128));
    send_req(mk(32'h7F7F_7F7F, 32'h8080_8080, 3'd4, 1'b1, 32'h3F80_0000,
                32'hBF80_0000, 20'sh7F000, 8'sd127));
    send_req(mk(32'hFFFF_FFFF, 32'h7F7F_7F7F, 3'd0, 1'b0, 0, 0, 0, 0));
    send_req(mk(32'h0102_0304, 32'h0506_0708, 3'd5, 1'b0, 0, 0, 0, 0));
    send_req(mk(32'h0102_0304, 32'h0506_0708, 3'd7, 1'b0, 0, 0, 0, 0));
    send_req(mk(32'h0000_0011, 32'h0000_0022, 3'd6, 1'b1, 32'h4000_0000,
                32'h3F00_0000, 20'sd1000, -8'sd3));
    send_req(mk(32'h0000_0001, 32'h0000_0001, 3'd1, 1'b1, 32'h7F80_0000,
                32'h0000_0000, 0, 0));
    send_req(mk(32'h0000_0001, 32'h0000_0001, 3'd1, 1'b1, 32'h7FC1_2345,
                32'h3F80_0000, 0, 0));
    send_req(mk(32'h0000_0000, 32'h0000_0000, 3'd4, 1'b1, 32'h7F80_0000,
                32'h3F80_0000, 0, 0));
    send_req(mk(32'h7F7F_7F7F, 32'h7F7F_7F7F, 3'd4, 1'b1, 32'h7F7F_FFFF,
                32'h7F7F_FFFF, 0, 0));
    send_req(mk(32'h0000_0001, 32'h0000_00FF, 3'd1, 1'b1, 32'h0000_0001,
                32'h3F00_0000, 0, 0));
    send_req(mk(32'h0000_0003, 32'h0000_0001, 3'd1, 1'b1, 32'h0080_0000,
                32'h3E80_0000, 0, 0));
    send_req(mk(32'h0000_0000, 32'h0000_0000, 3'd4, 1'b1, 32'hBF80_0000,
                32'h3F80_0000, 0, 0));
    // large odd sum rounds when converted to single
    send_req(mk(32'h0000_0001, 32'h0000_0001, 3'd1, 1'b1, 32'h3F80_0000,
                32'h3F80_0000, 20'sh7F001, -8'sd128));
    write_mode(1'b0);
    send_req(mk(32'h8080_8080, 32'h7F7F_7F7F, 3'd4, 1'b1, 32'h3F80_0000,
                32'h3F80_0000, 20'sh7FFFF, 8'sd127));
  endtask

  // long dot that drives the correction into saturation
  task automatic test_saturation();
    write_mode(1'b1);
    repeat (1040)
      send_req(mk(32'h8080_8080, 32'h8080_8080, 3'd4, 1'b0, 0, 0, 0, 0));
    send_req(mk(32'h8080_8080, 32'h8080_8080, 3'd4, 1'b1, 32'h3F80_0000,
                32'h3F80_0000, 20'sh80000, 8'sd127));
  endtask

  // random dot products of a few requests each
  task automatic test_random(int items, logic m);
    int n, len;
    write_mode(m);
    n = 0;
    while (n < items) begin
      len = ($urandom_range(4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      for (int k = 0; k < len; k++) send_req(rand_req(k == len - 1));
      n += len;
    end
  endtask

  // receiver holds off while requests keep coming, then the sender pauses
  task automatic test_backpressure();
    hold_cycles = 200;
    for (int k = 0; k < 40; k++) send_req(rand_req(k % 2 == 1));
    drain();
    for (int k = 0; k < 10; k++) send_req(rand_req(1'b1));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    idle_pct = 0;
    stall_pct = 0;
    test_random(40, 1'b0);
    idle_pct = 75;
    test_random(40, 1'b1);
    idle_pct = 0;
    stall_pct = 75;
    test_random(40, 1'b0);
    idle_pct = 9;
    stall_pct = 9;
    test_random(40, 1'b1);
    test_backpressure();
    drain();
    if (errors == 0) $display("int8_dot_dequant_unit_tb: done, clean");
    else $display("int8_dot_dequant_unit_tb: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("int8_dot_dequant_unit_tb: done, errors");
    $finish;
  end

endmodule

### files.f
src/idd_pkg.sv
src/idd_lane.sv
src/idd_fmul.sv
src/int8_dot_dequant_unit.sv
test/int8_dot_dequant_unit_tb.sv
